// ===== rtl/core/mlt_pkg.sv =====
// Package for the mutex lock table: request action codes, result status
// codes, entry tag and kind codes, and the control state type.
// No dependencies.
package mlt_pkg;

  // Request actions
  typedef enum logic [2:0] {
    ACT_INIT       = 3'd0,
    ACT_DESTROY    = 3'd1,
    ACT_LOCK       = 3'd2,
    ACT_TRYLOCK    = 3'd3,
    ACT_UNLOCK     = 3'd4,
    ACT_CONSISTENT = 3'd5
  } action_t;

  // Result status codes
  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_INVALID       = 4'd1,
    ST_BUSY          = 4'd2,
    ST_DEADLOCK      = 4'd3,
    ST_NOT_OWNER     = 4'd4,
    ST_OWNER_DEAD    = 4'd5,
    ST_UNRECOVERABLE = 4'd6,
    ST_WAIT          = 4'd7,
    ST_COUNT_FULL    = 4'd8
  } status_t;

  // Entry tag: statically initialized, valid, destroyed
  localparam logic [1:0] TAG_STATIC    = 2'd0;
  localparam logic [1:0] TAG_VALID     = 2'd1;
  localparam logic [1:0] TAG_DESTROYED = 2'd2;

  // Mutex kinds; the last code names no kind
  localparam logic [1:0] KIND_NORMAL     = 2'd0;
  localparam logic [1:0] KIND_ERRORCHECK = 2'd1;
  localparam logic [1:0] KIND_RECURSIVE  = 2'd2;
  localparam logic [1:0] KIND_NONE       = 2'd3;

  // Contention states
  localparam logic [1:0] CONT_FREE     = 2'd0;
  localparam logic [1:0] CONT_HELD     = 2'd1;
  localparam logic [1:0] CONT_WAITERS  = 2'd2;

  // Control states
  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_EXEC  = 2'd2
  } ctrl_state_t;

endpackage

// ===== rtl/core/mutex_lock_table_unit.sv =====
// Mutex lock table: one table memory with read-modify-write per request.
// Depends on mlt_pkg.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  request | in        | req_valid / req_ready | action mutex_id thread_id after_wake
//          |           |                       | owner_alive init_type init_robust
//  result  | out       | rsp_valid / rsp_ready | status wake_one
//
// For each request the accept cycle issues the table read; state S_EXEC then
// updates the entry from the registered read word and writes it back, so one
// request is in flight at a time.
// After reset a clearing pass writes every entry to its static state, one entry
// a cycle; req_ready stays low during it.
// A result not yet taken holds the update cycle until the result register frees.
module mutex_lock_table_unit
  import mlt_pkg::*;
#(
  parameter int MUTEX_COUNT  = 64,
  parameter int THREAD_COUNT = 256,
  parameter int COUNT_MAX    = 255,
  localparam int ID_W        = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1,
  localparam int TH_W        = $clog2(THREAD_COUNT)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic [2:0]           action,
  input  logic [ID_W-1:0]      mutex_id,
  input  logic [TH_W-1:0]      thread_id,
  input  logic                 after_wake,
  input  logic                 owner_alive,
  input  logic [1:0]           init_type,
  input  logic                 init_robust,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output logic [3:0]           status,
  output logic                 wake_one
);

  localparam int CNT_W = $clog2(COUNT_MAX + 1);

  // One table entry
  typedef struct packed {
    logic [1:0]       tag;
    logic [1:0]       kind;
    logic             robust;
    logic [TH_W-1:0]  owner;
    logic             present;
    logic [CNT_W-1:0] count;
    logic             dead;
    logic             unrec;
    logic [1:0]       cont;
  } entry_t;

  ctrl_state_t state, state_next;

  logic [ID_W-1:0]  clr_addr;
  logic             clr_last;

  // Latched request word
  logic [2:0]       req_action;
  logic [ID_W-1:0]  req_mutex;
  logic [TH_W-1:0]  req_thread;
  logic             req_wake;
  logic             req_alive;
  logic [1:0]       req_type;
  logic             req_robust;

  entry_t           mem [MUTEX_COUNT];
  entry_t           rd_data;
  entry_t           cur;
  entry_t           ent_next;
  entry_t           wr_data;
  logic [ID_W-1:0]  wr_addr;
  logic             wr_en;

  logic             req_fire;
  logic             exec_fire;
  logic             sel_ok;
  logic             held;
  logic             at_max;
  status_t          st;
  logic             wake;

  assign req_fire  = req_valid && req_ready;
  assign clr_last  = (clr_addr == ID_W'(MUTEX_COUNT - 1));

  // Next control state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_last) state_next = S_IDLE;
      S_IDLE:  if (req_valid) state_next = S_EXEC;
      S_EXEC:  if (!rsp_valid || rsp_ready) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // Control outputs
  always_comb begin
    req_ready = 1'b0;
    exec_fire = 1'b0;
    unique case (state)
      S_IDLE:  req_ready = 1'b1;
      S_EXEC:  exec_fire = !rsp_valid || rsp_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR && !clr_last) clr_addr <= clr_addr + 1'b1;
    end
  end

  // Latch the request word
  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_action <= action;
      req_mutex  <= mutex_id;
      req_thread <= thread_id;
      req_wake   <= after_wake;
      req_alive  <= owner_alive;
      req_type   <= init_type;
      req_robust <= init_robust;
    end
  end

  // Table memory: registered read at accept, one write port
  always_ff @(posedge clk) begin
    if (req_fire) rd_data <= mem[mutex_id];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Select the write: clearing pass, or entry update
  always_comb begin
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = exec_fire && sel_ok;
      wr_addr = req_mutex;
      wr_data = ent_next;
    end
  end

  // Check the selectors
  always_comb begin
    sel_ok = (req_action <= ACT_CONSISTENT)
          && ({1'b0, req_mutex} < (ID_W + 1)'(MUTEX_COUNT))
          && ({1'b0, req_thread} < (TH_W + 1)'(THREAD_COUNT))
          && !(req_action == ACT_INIT && req_type == KIND_NONE);
  end

  // Auto-initialize a static entry on lock, trylock and unlock
  always_comb begin
    cur = rd_data;
    if ((req_action == ACT_LOCK || req_action == ACT_TRYLOCK || req_action == ACT_UNLOCK)
        && rd_data.tag == TAG_STATIC) begin
      cur     = '0;
      cur.tag = TAG_VALID;
    end
  end

  assign held   = cur.present && (cur.owner == req_thread);
  assign at_max = (cur.count >= CNT_W'(COUNT_MAX));

  // Update the entry and form the result
  always_comb begin
    ent_next = cur;
    st       = ST_INVALID;
    wake     = 1'b0;
    if (sel_ok) begin
      if (req_action == ACT_INIT) begin
        ent_next        = '0;
        ent_next.tag    = TAG_VALID;
        ent_next.kind   = req_type;
        ent_next.robust = req_robust;
        st              = ST_OK;
      end else if (cur.tag == TAG_VALID) begin
        unique case (req_action)
          ACT_DESTROY: begin
            if (cur.present) begin
              st = ST_BUSY;
            end else begin
              ent_next.tag = TAG_DESTROYED;
              st           = ST_OK;
            end
          end
          ACT_LOCK: begin
            priority if (req_wake) begin
              if (cur.cont == CONT_FREE) begin
                ent_next.owner   = req_thread;
                ent_next.present = 1'b1;
                ent_next.count   = '0;
                ent_next.cont    = CONT_WAITERS;
                st               = ST_OK;
              end else begin
                ent_next.cont = CONT_WAITERS;
                st            = ST_WAIT;
              end
            end else if (cur.robust && cur.unrec) begin
              st = ST_UNRECOVERABLE;
            end else if (cur.kind != KIND_NORMAL && held) begin
              if (cur.kind == KIND_RECURSIVE) begin
                if (at_max) begin
                  st = ST_COUNT_FULL;
                end else begin
                  ent_next.count = cur.count + 1'b1;
                  st             = ST_OK;
                end
              end else begin
                st = ST_DEADLOCK;
              end
            end else if (cur.cont == CONT_FREE) begin
              ent_next.owner   = req_thread;
              ent_next.present = 1'b1;
              ent_next.count   = '0;
              ent_next.cont    = CONT_HELD;
              st               = ST_OK;
            end else if (cur.robust && cur.present && !req_alive) begin
              // take over from a dead owner
              ent_next.dead    = 1'b1;
              ent_next.owner   = req_thread;
              ent_next.present = 1'b1;
              ent_next.count   = '0;
              ent_next.cont    = CONT_HELD;
              st               = ST_OWNER_DEAD;
            end else begin
              ent_next.cont = CONT_WAITERS;
              st            = ST_WAIT;
            end
          end
          ACT_TRYLOCK: begin
            priority if (cur.kind == KIND_RECURSIVE && held) begin
              if (at_max) begin
                st = ST_COUNT_FULL;
              end else begin
                ent_next.count = cur.count + 1'b1;
                st             = ST_OK;
              end
            end else if (cur.cont == CONT_FREE) begin
              ent_next.owner   = req_thread;
              ent_next.present = 1'b1;
              ent_next.count   = '0;
              ent_next.cont    = CONT_HELD;
              st               = ST_OK;
            end else begin
              st = ST_BUSY;
            end
          end
          ACT_UNLOCK: begin
            priority if (!held) begin
              st = ST_NOT_OWNER;
            end else if (cur.kind == KIND_RECURSIVE && cur.count != '0) begin
              ent_next.count = cur.count - 1'b1;
              st             = ST_OK;
            end else begin
              // a robust owner that died and was never made consistent
              if (cur.robust && cur.dead) begin
                ent_next.unrec = 1'b1;
                ent_next.dead  = 1'b0;
              end
              ent_next.owner   = '0;
              ent_next.present = 1'b0;
              ent_next.count   = '0;
              ent_next.cont    = CONT_FREE;
              wake             = (cur.cont == CONT_WAITERS);
              st               = ST_OK;
            end
          end
          ACT_CONSISTENT: begin
            if (cur.robust && held && cur.dead) begin
              ent_next.dead = 1'b0;
              st            = ST_OK;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      status   <= st;
      wake_one <= wake;
    end
  end

endmodule
